// ----- rtl/rrps_pkg.sv -----
// Package for the round-robin process scheduler.
// Holds constants, item codes, controller state and command/status types.
// No dependencies.
package rrps_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 8;
    localparam int unsigned SLOT_IDX_MAX_W = 6;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_SLICE_TICKS = 1'b0;

    localparam logic [7:0]  SLICE_TICKS_RESET = 8'd15;
    localparam logic [15:0] SP_RESET = 16'hFF00;

    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_LAUNCH    = 2'd1;
    localparam logic [1:0] KIND_TERMINATE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_READ,
        ST_OUTPUT
    } sched_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic read_done;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic go_scan;
        logic scan_end;
        logic need_read;
        logic out_free;
    } dp_status_t;

    // segment of a slot: (slot + 2) * 0x1000, cut to 16 bits
    function automatic logic [15:0] seg_of(input logic [SLOT_IDX_MAX_W-1:0] idx);
        logic [SLOT_IDX_MAX_W-1:0] sum;
        begin
            sum = idx + SLOT_IDX_MAX_W'(2);
            seg_of = {sum[3:0], 12'h000};
        end
    endfunction

endpackage

// ----- rtl/rrps_in_if.sv -----
// Input channel of the round-robin process scheduler.
// Carries one request item; no dependencies.
interface rrps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] cur_segment;
    logic [15:0] cur_sp;

    modport source (output valid, kind, cur_segment, cur_sp, input ready);
    modport sink (input valid, kind, cur_segment, cur_sp, output ready);
endinterface

// ----- rtl/rrps_out_if.sv -----
// Result channel of the round-robin process scheduler.
// Carries one result item; no dependencies.
interface rrps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] resume_segment;
    logic [15:0] resume_sp;
    logic        switched;
    logic [2:0]  slot;
    logic        table_full;

    modport source (output valid, resume_segment, resume_sp, switched, slot, table_full,
                    input ready);
    modport sink (input valid, resume_segment, resume_sp, switched, slot, table_full,
                  output ready);
endinterface

// ----- rtl/rrps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrps_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rrps_ctrl.sv -----
// Controller state machine of the round-robin process scheduler.
// Depends on rrps_pkg; drives commands into rrps_dp.
module rrps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrps_pkg::dp_status_t status,
    output rrps_pkg::dp_cmd_t    cmd
);

    rrps_pkg::sched_state_t state_reg;
    rrps_pkg::sched_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrps_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrps_pkg::ST_EXEC;
                end
            end
            rrps_pkg::ST_EXEC:
            begin
                state_next = status.go_scan ? rrps_pkg::ST_SCAN : rrps_pkg::ST_OUTPUT;
            end
            rrps_pkg::ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = status.need_read ? rrps_pkg::ST_READ : rrps_pkg::ST_OUTPUT;
                end
            end
            rrps_pkg::ST_READ:
            begin
                state_next = rrps_pkg::ST_OUTPUT;
            end
            rrps_pkg::ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    state_next = rrps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrps_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            rrps_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            rrps_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            rrps_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            rrps_pkg::ST_READ:
            begin
                cmd.read_done = 1'b1;
            end
            rrps_pkg::ST_OUTPUT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/rrps_dp.sv -----
// Datapath of the round-robin process scheduler: slot table, tick counter,
// slot scanner, stack pointer RAM and result register.
// Depends on rrps_pkg, rrps_ram and rrps_out_if.
module rrps_dp #(
    parameter int unsigned SLOT_COUNT = rrps_pkg::SLOT_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           slice_ticks,
    input  logic [1:0]           in_kind,
    input  logic [15:0]          in_cur_segment,
    input  logic [15:0]          in_cur_sp,
    input  rrps_pkg::dp_cmd_t    cmd,
    output rrps_pkg::dp_status_t status,
    rrps_out_if.source           result_out
);

    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    logic [1:0]            kind_reg;
    logic [15:0]           seg_reg;
    logic [15:0]           sp_reg;

    logic [7:0]            tick_count_reg, tick_count_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [SLOT_COUNT-1:0] sp_valid_reg, sp_valid_next;
    logic [SLOT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0]     scan_cnt_reg, scan_cnt_next;

    logic                  res_load;
    logic [15:0]           res_seg_next;
    logic [15:0]           res_sp_next;
    logic                  res_sw_next;
    logic [SLOT_W-1:0]     res_slot_next;
    logic                  res_full_next;

    logic [15:0]           res_seg_reg;
    logic [15:0]           res_sp_reg;
    logic                  res_sw_reg;
    logic [2:0]            res_slot_reg;
    logic                  res_full_reg;
    logic                  out_valid_reg;

    logic [7:0]            tick_inc;
    logic                  slice_end;
    logic                  hit_active;
    logic                  is_tick;
    logic                  scan_last;
    logic                  scan_found;
    logic [SLOT_W-1:0]     idx_wrap;
    logic [SLOT_W-1:0]     cur_wrap;

    logic                  ram_we;
    logic                  ram_re;
    logic [15:0]           ram_rdata;

    assign tick_inc   = tick_count_reg + 8'd1;
    assign slice_end  = tick_inc >= slice_ticks;
    assign hit_active = active_reg[scan_idx_reg];
    assign is_tick    = kind_reg == rrps_pkg::KIND_TICK;
    assign idx_wrap   = (scan_idx_reg == LAST_SLOT) ? '0 : scan_idx_reg + SLOT_W'(1);
    assign cur_wrap   = (cur_slot_reg == LAST_SLOT) ? '0 : cur_slot_reg + SLOT_W'(1);
    assign scan_last  = is_tick ? (scan_cnt_reg == LAST_SLOT) : (scan_idx_reg == LAST_SLOT);
    assign scan_found = is_tick ? hit_active : !hit_active;

    assign status.go_scan   = (is_tick && slice_end) || (kind_reg == rrps_pkg::KIND_LAUNCH);
    assign status.scan_end  = scan_found || scan_last;
    assign status.need_read = is_tick && hit_active;
    assign status.out_free  = !out_valid_reg || result_out.ready;

    assign ram_we = cmd.exec && is_tick && slice_end;
    assign ram_re = cmd.scan && is_tick && hit_active;

    rrps_ram #(
        .WIDTH (16),
        .DEPTH (SLOT_COUNT)
    ) u_sp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_slot_reg),
        .wdata (sp_reg),
        .re    (ram_re),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        tick_count_next = tick_count_reg;
        cur_slot_next   = cur_slot_reg;
        active_next     = active_reg;
        sp_valid_next   = sp_valid_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_load        = 1'b0;
        res_seg_next    = '0;
        res_sp_next     = '0;
        res_sw_next     = 1'b0;
        res_slot_next   = '0;
        res_full_next   = 1'b0;

        if (cmd.exec)
        begin
            priority if (kind_reg == rrps_pkg::KIND_TICK)
            begin
                if (slice_end)
                begin
                    tick_count_next             = '0;
                    sp_valid_next[cur_slot_reg] = 1'b1;
                    scan_idx_next               = cur_wrap;
                    scan_cnt_next               = SLOT_W'(1);
                end
                else
                begin
                    tick_count_next = tick_inc;
                    res_load        = 1'b1;
                    res_seg_next    = seg_reg;
                    res_sp_next     = sp_reg;
                    res_slot_next   = cur_slot_reg;
                end
            end
            else if (kind_reg == rrps_pkg::KIND_LAUNCH)
            begin
                scan_idx_next = '0;
            end
            else if (kind_reg == rrps_pkg::KIND_TERMINATE)
            begin
                active_next[cur_slot_reg] = 1'b0;
                res_load                  = 1'b1;
                res_slot_next             = cur_slot_reg;
            end
            else
            begin
                res_load = 1'b1;
            end
        end

        if (cmd.scan)
        begin
            if (is_tick)
            begin
                priority if (hit_active)
                begin
                    cur_slot_next = scan_idx_reg;
                end
                else if (scan_last)
                begin
                    res_load      = 1'b1;
                    res_seg_next  = seg_reg;
                    res_sp_next   = sp_reg;
                    res_slot_next = cur_slot_reg;
                end
                else
                begin
                    scan_idx_next = idx_wrap;
                    scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                end
            end
            else
            begin
                priority if (!hit_active)
                begin
                    active_next[scan_idx_reg] = 1'b1;
                    res_load                  = 1'b1;
                    res_seg_next  = rrps_pkg::seg_of(rrps_pkg::SLOT_IDX_MAX_W'(scan_idx_reg));
                    res_slot_next = scan_idx_reg;
                end
                else if (scan_last)
                begin
                    res_load      = 1'b1;
                    res_full_next = 1'b1;
                end
                else
                begin
                    scan_idx_next = idx_wrap;
                end
            end
        end

        if (cmd.read_done)
        begin
            res_load      = 1'b1;
            res_seg_next  = rrps_pkg::seg_of(rrps_pkg::SLOT_IDX_MAX_W'(cur_slot_reg));
            res_sp_next   = sp_valid_reg[cur_slot_reg] ? ram_rdata : rrps_pkg::SP_RESET;
            res_sw_next   = 1'b1;
            res_slot_next = cur_slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            cur_slot_reg   <= '0;
            active_reg     <= '0;
            sp_valid_reg   <= '0;
            scan_idx_reg   <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            cur_slot_reg   <= cur_slot_next;
            active_reg     <= active_next;
            sp_valid_reg   <= sp_valid_next;
            scan_idx_reg   <= scan_idx_next;
            scan_cnt_reg   <= scan_cnt_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            seg_reg  <= in_cur_segment;
            sp_reg   <= in_cur_sp;
        end
        if (res_load)
        begin
            res_seg_reg  <= res_seg_next;
            res_sp_reg   <= res_sp_next;
            res_sw_reg   <= res_sw_next;
            res_slot_reg <= 3'(res_slot_next);
            res_full_reg <= res_full_next;
        end
        if (cmd.load_out)
        begin
            result_out.resume_segment <= res_seg_reg;
            result_out.resume_sp      <= res_sp_reg;
            result_out.switched       <= res_sw_reg;
            result_out.slot           <= res_slot_reg;
            result_out.table_full     <= res_full_reg;
        end
    end

    assign result_out.valid = out_valid_reg;

endmodule

// ----- rtl/round_robin_process_scheduler.sv -----
// Round-robin process scheduler: top level with APB register and assertions.
// Depends on rrps_pkg, rrps_in_if, rrps_out_if, rrps_ctrl and rrps_dp.
//
// One item at a time enters and each gives one result. A tick that does not
// end the slice, a terminate or an unused kind goes from the execute state
// straight to the output state. A launch scans the slots from the lowest, one
// slot per cycle, examining up to SLOT_COUNT slots. A tick that ends the slice
// scans from the slot after the current one, one per cycle (up to
// SLOT_COUNT-1), and a switch passes through a read state for the stack
// pointer RAM read. A new item is taken the cycle after a result enters the
// output register, even if it is not yet taken.
module round_robin_process_scheduler #(
    parameter int unsigned SLOT_COUNT = rrps_pkg::SLOT_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rrps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rrps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rrps_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    rrps_in_if.sink                         item_in,
    rrps_out_if.source                      result_out
);

    logic [7:0]           slice_ticks_reg;
    rrps_pkg::dp_cmd_t    cmd;
    rrps_pkg::dp_status_t status;
    logic                 in_ready;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_ticks_reg <= rrps_pkg::SLICE_TICKS_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == rrps_pkg::REG_SLICE_TICKS))
        begin
            slice_ticks_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == rrps_pkg::REG_SLICE_TICKS)
                    ? {(rrps_pkg::APB_DATA_W - 8)'(0), slice_ticks_reg} : '0;

    assign item_in.ready = in_ready;

    rrps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rrps_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .slice_ticks    (slice_ticks_reg),
        .in_kind        (item_in.kind),
        .in_cur_segment (item_in.cur_segment),
        .in_cur_sp      (item_in.cur_sp),
        .cmd            (cmd),
        .status         (status),
        .result_out     (result_out)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_in.valid && item_in.ready |=> !item_in.ready)
        else $error("second item accepted while one is in work");

    a_switch_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> !(result_out.switched && result_out.table_full))
        else $error("result both switched and table full");

    a_switch_segment: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.switched |-> result_out.resume_segment[11:0] == 12'h000)
        else $error("switched result with misaligned segment");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.table_full
        |-> result_out.slot == 3'd0 && result_out.resume_segment == 16'h0000)
        else $error("table full result carries slot data");
`endif

endmodule
